>>> hdl/bba_pkg.sv
// Shared types, codes and helpers of the bitmap block allocator
package bba_pkg;

	localparam int WORD_BITS = 32;
	localparam int POS_W     = 5;
	localparam int BLOCK_W   = 12;
	localparam int CMD_W     = 2;
	localparam int WIDX_W    = 7;

	typedef logic [WORD_BITS-1:0] map_word_t;
	typedef logic [POS_W-1:0]     bit_pos_t;
	typedef logic [BLOCK_W-1:0]   block_num_t;
	typedef logic [CMD_W-1:0]     cmd_t;

	localparam cmd_t CMD_ALLOC = 2'd0;
	localparam cmd_t CMD_FREE  = 2'd1;
	localparam cmd_t CMD_LOAD  = 2'd2;

	localparam map_word_t FULL_WORD = 32'hffff_ffff;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Result of a search for the first clear bit, counted from bit 31 down
	typedef struct packed {
		logic     found;
		bit_pos_t pos;
	} clear_hit_t;

	function automatic clear_hit_t first_clear_from_top(input map_word_t word);
		clear_hit_t hit;
		hit.found = 1'b0;
		hit.pos   = '0;
		// descending scan so the lowest position wins
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (!word[WORD_BITS-1-p]) begin
				hit.found = 1'b1;
				hit.pos   = POS_W'(p);
			end
		end
		return hit;
	endfunction

endpackage

>>> hdl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/bitmap_block_allocator.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// input    | in_valid, in_stall  | cmd, block_number, word_index, word_value
// output   | out_valid, out_stall| granted_block, status
//
// Each item passes through four steps: accept, map memory read, modify, write back.
// The read-modify-write on the map memory sets these steps; in_stall holds off new items until write back.
// A per-word full vector with a priority encoder picks the word to allocate from.
// Reset clears the per-word valid and full bits at once; no clearing pass is run.
// A result waits in the output register; a stalled output holds the item in write back.
module bitmap_block_allocator #(
	parameter int MAP_WORDS = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  bba_pkg::cmd_t         cmd,
	input  logic [11:0]           block_number,
	input  logic [6:0]            word_index,
	input  bba_pkg::map_word_t    word_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output bba_pkg::block_num_t   granted_block,
	output logic                  status
);

	localparam int WORD_AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int XW      = (WORD_AW > bba_pkg::WIDX_W) ? WORD_AW : bba_pkg::WIDX_W;
	localparam int GW      = WORD_AW + bba_pkg::POS_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_MOD   = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0]                state_q;
	logic [MAP_WORDS-1:0]      valid_q;
	logic [MAP_WORDS-1:0]      full_q;

	bba_pkg::cmd_t             cmd_q;
	logic [WORD_AW-1:0]        addr_q;
	logic                      hit_q;
	bba_pkg::bit_pos_t         pos_q;
	bba_pkg::map_word_t        load_q;
	bba_pkg::map_word_t        new_word_q;
	logic                      we_q;
	bba_pkg::block_num_t       granted_q;
	logic                      status_q;

	logic                      out_valid_q;
	bba_pkg::block_num_t       out_block_q;
	logic                      out_status_q;

	logic                      in_take;
	logic                      wb_go;
	logic                      any_free;
	logic [WORD_AW-1:0]        free_idx;
	logic [XW-1:0]             free_word_x;
	logic [XW-1:0]             load_word_x;
	logic                      free_in_range;
	logic                      load_in_range;
	bba_pkg::map_word_t        rd_word;
	bba_pkg::map_word_t        cur_word;
	bba_pkg::clear_hit_t       clr;
	logic [GW-1:0]             grant_full;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign wb_go    = (state_q == ST_WRITE) && (!out_valid_q || !out_stall);

	// first word that is not full, lowest index wins
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = MAP_WORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				any_free = 1'b1;
				free_idx = WORD_AW'(i);
			end
		end
	end

	// word addresses of free and load items, with range checks
	assign free_word_x   = XW'(block_number[11:5]);
	assign load_word_x   = XW'(word_index);
	assign free_in_range = (int'(block_number[11:5]) < MAP_WORDS);
	assign load_in_range = (int'(word_index) < MAP_WORDS);

	// accept: latch the item and the target word
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q  <= cmd;
			load_q <= word_value;
			pos_q  <= block_number[4:0];
			unique case (cmd)
				bba_pkg::CMD_ALLOC: begin
					addr_q <= free_idx;
					hit_q  <= any_free;
				end
				bba_pkg::CMD_FREE: begin
					addr_q <= free_word_x[WORD_AW-1:0];
					hit_q  <= free_in_range;
				end
				bba_pkg::CMD_LOAD: begin
					addr_q <= load_word_x[WORD_AW-1:0];
					hit_q  <= load_in_range;
				end
				default: begin
					addr_q <= '0;
					hit_q  <= 1'b0;
				end
			endcase
		end
	end

	// map memory; an entry never written since reset reads as zero
	bba_ram #(
		.WIDTH(bba_pkg::WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (wb_go && we_q),
		.waddr(addr_q),
		.wdata(new_word_q),
		.re   (state_q == ST_READ),
		.raddr(addr_q),
		.rdata(rd_word)
	);

	assign cur_word   = valid_q[addr_q] ? rd_word : '0;
	assign clr        = bba_pkg::first_clear_from_top(cur_word);
	assign grant_full = {addr_q, clr.pos};

	// modify: build the new word and the result
	always_ff @(posedge clk) begin
		if (state_q == ST_MOD) begin
			new_word_q <= cur_word;
			we_q       <= 1'b0;
			granted_q  <= '0;
			status_q   <= bba_pkg::STATUS_DONE;
			case (cmd_q)
				bba_pkg::CMD_ALLOC: begin
					if (hit_q) begin
						new_word_q <= cur_word | (bba_pkg::map_word_t'(1) << (~clr.pos));
						we_q       <= 1'b1;
						granted_q  <= bba_pkg::BLOCK_W'(grant_full);
					end else begin
						status_q <= bba_pkg::STATUS_FULL;
					end
				end
				bba_pkg::CMD_FREE: begin
					new_word_q <= cur_word & ~(bba_pkg::map_word_t'(1) << (~pos_q));
					we_q       <= hit_q;
				end
				bba_pkg::CMD_LOAD: begin
					new_word_q <= load_q;
					we_q       <= hit_q;
				end
				default: begin
					we_q <= 1'b0;
				end
			endcase
		end
	end

	// sequencer and per-word valid and full bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			full_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
						if (we_q) begin
							valid_q[addr_q] <= 1'b1;
							full_q[addr_q]  <= (new_word_q == bba_pkg::FULL_WORD);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			out_block_q  <= granted_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted_block = out_block_q;
	assign status        = out_status_q;

endmodule

>>> tb/bitmap_block_allocator_checker.sv
// Watches both channels, keeps a shadow allocation map and compares each result
module bitmap_block_allocator_checker #(
	parameter int MAP_WORDS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  bba_pkg::cmd_t       cmd,
	input  logic [11:0]         block_number,
	input  logic [6:0]          word_index,
	input  bba_pkg::map_word_t  word_value,
	input  logic                out_valid,
	input  logic                out_stall,
	input  bba_pkg::block_num_t granted_block,
	input  logic                status,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		bba_pkg::block_num_t block;
		logic                status;
	} grant_t;

	bba_pkg::map_word_t alloc_map [MAP_WORDS];
	grant_t             grants_due [$];
	grant_t             due;
	int                 results_seen;

	initial begin
		fail_count   = 0;
		pending      = 0;
		results_seen = 0;
	end

	// one line per mismatch, and a count
	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t ns: result %0d: %s", $time, results_seen, what);
	endtask

	// first-fit allocate, free and word load on the shadow map
	function automatic grant_t apply_command(input bba_pkg::cmd_t c, input logic [11:0] blk,
			input logic [6:0] widx, input bba_pkg::map_word_t val);
		grant_t g;
		bit     found;
		int     w;
		int     p;
		g.block  = '0;
		g.status = bba_pkg::STATUS_DONE;
		found    = 1'b0;
		case (c)
			bba_pkg::CMD_ALLOC: begin
				for (int i = 0; i < MAP_WORDS; i++) begin
					if (!found && alloc_map[i] != bba_pkg::FULL_WORD) begin
						for (int j = 0; j < bba_pkg::WORD_BITS; j++) begin
							// bit 31 holds the lowest block of the word
							if (!found && !alloc_map[i][bba_pkg::WORD_BITS - 1 - j]) begin
								alloc_map[i][bba_pkg::WORD_BITS - 1 - j] = 1'b1;
								g.block = bba_pkg::block_num_t'(i * bba_pkg::WORD_BITS + j);
								found   = 1'b1;
							end
						end
					end
				end
				if (!found)
					g.status = bba_pkg::STATUS_FULL;
			end
			bba_pkg::CMD_FREE: begin
				if (int'(blk) < MAP_WORDS * bba_pkg::WORD_BITS) begin
					w = int'(blk) / bba_pkg::WORD_BITS;
					p = int'(blk) % bba_pkg::WORD_BITS;
					alloc_map[w][bba_pkg::WORD_BITS - 1 - p] = 1'b0;
				end
			end
			bba_pkg::CMD_LOAD: begin
				if (int'(widx) < MAP_WORDS)
					alloc_map[widx] = val;
			end
			default: begin
			end
		endcase
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (alloc_map[i])
				alloc_map[i] = '0;
			grants_due.delete();
			pending = 0;
		end else begin
			if (in_valid && !in_stall)
				grants_due.push_back(apply_command(cmd, block_number, word_index, word_value));
			// compare against the oldest outstanding item
			if (out_valid && !out_stall) begin
				results_seen++;
				if (grants_due.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					due = grants_due.pop_front();
					if (granted_block !== due.block)
						report_mismatch($sformatf("granted_block %0d, expected %0d",
							granted_block, due.block));
					if (status !== due.status)
						report_mismatch($sformatf("status %b, expected %b", status, due.status));
				end
			end
			pending = grants_due.size();
		end
	end

endmodule

>>> tb/bitmap_block_allocator_tb.sv
module bitmap_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int            MAP_WORDS  = 128;
	localparam int            ITEM_GOAL  = 900;
	localparam int            LONG_HOLD  = 200;
	localparam bba_pkg::cmd_t CMD_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	bba_pkg::cmd_t       cmd;
	logic [11:0]         block_number;
	logic [6:0]          word_index;
	bba_pkg::map_word_t  word_value;
	logic                out_valid;
	logic                out_stall;
	bba_pkg::block_num_t granted_block;
	logic                status;

	int fail_count;
	int pending;
	int items_sent;
	int nogap_left;

	always #1 clk = ~clk;

	bitmap_block_allocator #(
		.MAP_WORDS(MAP_WORDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.block_number(block_number),
		.word_index(word_index),
		.word_value(word_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_block(granted_block),
		.status(status)
	);

	bitmap_block_allocator_checker #(
		.MAP_WORDS(MAP_WORDS)
	) alloc_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.block_number(block_number),
		.word_index(word_index),
		.word_value(word_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_block(granted_block),
		.status(status),
		.fail_count(fail_count),
		.pending(pending)
	);

	function automatic logic [11:0] any_block();
		return 12'($urandom);
	endfunction

	function automatic logic [6:0] any_word_index();
		return 7'($urandom);
	endfunction

	// sender idle cycles: mostly none or short, a few long, sometimes a clean run
	function automatic int next_gap();
		int r;
		if (nogap_left > 0) begin
			nogap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			nogap_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one item and hold it until the block takes it
	task automatic send_item(input bba_pkg::cmd_t c, input logic [11:0] blk,
			input logic [6:0] widx, input bba_pkg::map_word_t val);
		int gap;
		gap = next_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		block_number <= blk;
		word_index   <= widx;
		word_value   <= val;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// load a nearly full map, use up the holes, run into full, then churn a little; may_break can end the load early
	task automatic fill_map(input bit may_break);
		int                 holes;
		int                 stop_at;
		int                 frees;
		bba_pkg::map_word_t v;
		holes   = 0;
		stop_at = MAP_WORDS;
		if (may_break && $urandom_range(0, 3) == 0)
			stop_at = $urandom_range(0, MAP_WORDS - 1);
		for (int w = 0; w < stop_at; w++) begin
			v = bba_pkg::FULL_WORD;
			if ($urandom_range(0, 15) == 0) begin
				v[$urandom_range(0, bba_pkg::WORD_BITS - 1)] = 1'b0;
				holes++;
			end
			send_item(bba_pkg::CMD_LOAD, any_block(), 7'(w), v);
		end
		if (stop_at < MAP_WORDS)
			return;
		repeat (holes + $urandom_range(1, 3))
			send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		frees = $urandom_range(1, 6);
		repeat (frees)
			send_item(bba_pkg::CMD_FREE, any_block(), any_word_index(), $urandom);
		repeat (frees + 1)
			send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
	endtask

	// random mix; frees and loads lean toward the low blocks that allocate hands out
	task automatic mixed_traffic(input int count);
		int                 r;
		int                 k;
		logic [11:0]        blk;
		logic [6:0]         widx;
		bba_pkg::map_word_t v;
		repeat (count) begin
			r    = $urandom_range(0, 99);
			blk  = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 191)) : any_block();
			widx = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7)) : any_word_index();
			k    = $urandom_range(0, 19);
			if (k < 6) begin
				v = $urandom;
			end else if (k < 10) begin
				v = bba_pkg::FULL_WORD;
			end else if (k < 13) begin
				v = '0;
			end else begin
				v = bba_pkg::FULL_WORD;
				v[$urandom_range(0, bba_pkg::WORD_BITS - 1)] = 1'b0;
			end
			if (r < 45)
				send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
			else if (r < 75)
				send_item(bba_pkg::CMD_FREE, blk, any_word_index(), $urandom);
			else if (r < 93)
				send_item(bba_pkg::CMD_LOAD, any_block(), widx, v);
			else
				send_item(CMD_UNUSED, any_block(), any_word_index(), $urandom);
		end
	endtask

	// result side: random stalls, one long hold-off once traffic is going
	initial begin
		int r;
		bit held;
		out_stall = 1'b0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && items_sent >= 300) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				held = 1'b1;
			end else if (r < 5) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end else if (r < 65) begin
				out_stall <= 1'b0;
				@(negedge clk);
			end else if (r < 93) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(8, 30)) @(negedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		int fills;
		bit drained_midway;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = bba_pkg::CMD_ALLOC;
		block_number   = '0;
		word_index     = '0;
		word_value     = '0;
		items_sent     = 0;
		nogap_left     = 0;
		fills          = 0;
		drained_midway = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed: first fit from an empty map, reuse after free, double free,
		// top block, unused command, word loads steering the search
		send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		send_item(bba_pkg::CMD_FREE, 12'd1, any_word_index(), $urandom);
		send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		send_item(bba_pkg::CMD_FREE, 12'd2, any_word_index(), $urandom);
		send_item(bba_pkg::CMD_FREE, 12'd2, any_word_index(), $urandom);
		send_item(bba_pkg::CMD_FREE, 12'd4095, any_word_index(), $urandom);
		send_item(CMD_UNUSED, 12'd4095, 7'd127, bba_pkg::FULL_WORD);
		send_item(bba_pkg::CMD_LOAD, any_block(), 7'd0, bba_pkg::FULL_WORD);
		send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		send_item(bba_pkg::CMD_LOAD, any_block(), 7'd1, 32'hffff_fffe);
		send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		send_item(bba_pkg::CMD_LOAD, any_block(), 7'd2, 32'h7fff_ffff);
		send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		send_item(bba_pkg::CMD_LOAD, any_block(), 7'd127, bba_pkg::FULL_WORD);
		send_item(bba_pkg::CMD_FREE, 12'd4095, any_word_index(), $urandom);
		send_item(bba_pkg::CMD_LOAD, any_block(), 7'd127, '0);
		send_item(bba_pkg::CMD_LOAD, any_block(), 7'd0, '0);
		send_item(bba_pkg::CMD_ALLOC, any_block(), any_word_index(), $urandom);
		send_item(bba_pkg::CMD_FREE, 12'd0, 7'd127, bba_pkg::FULL_WORD);
		send_item(bba_pkg::CMD_LOAD, 12'd4095, 7'd3, 32'haaaa_aaaa);
		wait_drained();

		// random part; the first fill always runs to a full map
		while (items_sent < ITEM_GOAL) begin
			if (!drained_midway && items_sent >= 600) begin
				wait_drained();
				drained_midway = 1'b1;
			end
			if (fills == 0 || $urandom_range(0, 99) < 20) begin
				fill_map(fills != 0);
				fills++;
			end else begin
				mixed_traffic($urandom_range(20, 60));
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("bitmap_block_allocator verification clean");
		else
			$display("bitmap_block_allocator verification failed");
		$finish;
	end

	// hang guard
	initial begin
		#1_000_000;
		$display("bitmap_block_allocator verification failed");
		$finish;
	end

endmodule

>>> files.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bitmap_block_allocator.sv
tb/bitmap_block_allocator_checker.sv
tb/bitmap_block_allocator_tb.sv
